// ===== hdl/sseg_pkg.sv =====
`timescale 1ns / 1ps
// Package for the supply sag envelope gain unit: widths, fixed-point constants,
// sequencer states and the output saturation function. No dependencies.
package sseg_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned DepthW  = 16;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned EnvW    = 24;
  localparam int unsigned SupW    = 25;
  localparam int unsigned OpW     = 26;
  localparam int unsigned ProdW   = 2 * OpW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [SupW-1:0] OneQ24    = 25'd16777216;
  localparam logic [SupW-1:0] MinSupply = 25'd5033165;
  localparam logic [SupW:0]   MaxDrop   = 26'd11744051;

  localparam logic [CfgIdxW-1:0] RegSagDepth    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAttackCoef  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegReleaseCoef = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDroopCoef   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRecoverCoef = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStereoEn    = 3'd5;

  localparam logic [DepthW-1:0] SagDepthRst    = 16'd18350;
  localparam logic [CoefW-1:0]  AttackCoefRst  = 24'd345900;
  localparam logic [CoefW-1:0]  ReleaseCoefRst = 24'd17467;
  localparam logic [CoefW-1:0]  DroopCoefRst   = 24'd13975;
  localparam logic [CoefW-1:0]  RecoverCoefRst = 24'd1092;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_ENV,
    S_ENVU,
    S_DRP,
    S_TGT,
    S_SUP,
    S_SUPU,
    S_LEFT,
    S_RIGHT,
    S_OUT
  } state_e;

  // round the Q1.23 x Q1.24 product back to Q1.23 and clamp to 24 bits
  function automatic logic signed [SampleW-1:0] sat_scale(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] rnd;
    logic signed [ProdW-25:0] r;
    rnd = p + ProdW'(signed'(64'sd8388608));
    r   = rnd[ProdW-1:24];
    if (r > (ProdW-24)'(signed'(32'sd8388607))) begin
      sat_scale = 24'sh7FFFFF;
    end else if (r < (ProdW-24)'(signed'(-32'sd8388608))) begin
      sat_scale = 24'sh800000;
    end else begin
      sat_scale = r[SampleW-1:0];
    end
  endfunction

endpackage

// ===== hdl/supply_sag_envelope_gain_unit.sv =====
`timescale 1ns / 1ps
// An accepted input beat steps through ENV, ENVU, DRP, TGT, SUP, SUPU, LEFT, RIGHT and OUT
// (only PASS when sag depth is zero) before its result is valid; one shared 26x26
// multiplier runs envelope, droop, supply slew and both sample scalings in turn.
// Input stalls while a beat is in flight; a finished result waits in the output register.
// Reset clears envelope to 0, supply to 1.0 and loads the default coefficients.
// Top level of the supply sag envelope gain unit; depends on sseg_pkg.
module supply_sag_envelope_gain_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sseg_pkg::SampleW-1:0]  left_sample_i,
  input  logic signed [sseg_pkg::SampleW-1:0]  right_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sseg_pkg::SampleW-1:0]  left_out_o,
  output logic signed [sseg_pkg::SampleW-1:0]  right_out_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [sseg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [sseg_pkg::CoefW-1:0]    cfg_data_i
);

  sseg_pkg::state_e state_q, state_d;

  logic [sseg_pkg::DepthW-1:0] sag_depth_q;
  logic [sseg_pkg::CoefW-1:0]  attack_coef_q, release_coef_q, droop_coef_q, recover_coef_q;
  logic                        stereo_en_q;

  logic [sseg_pkg::EnvW-1:0]  env_q, rect_q;
  logic [sseg_pkg::SupW-1:0]  supply_q, target_q;
  logic signed [sseg_pkg::SampleW-1:0] left_q, right_q, left_res_q;
  logic signed [sseg_pkg::ProdW-1:0]   prod_q;
  logic                        out_valid_q;
  logic signed [sseg_pkg::SampleW-1:0] left_out_q, right_out_q;

  logic in_acc, slot_free, load_out;
  logic signed [sseg_pkg::OpW-1:0] mul_a, mul_b;
  logic signed [sseg_pkg::ProdW-1:0] prod_d;

  logic [sseg_pkg::EnvW-1:0] mag_l, mag_r, rect_d;
  logic                      env_up, sup_up;
  logic [sseg_pkg::EnvW-1:0] env_diff;
  logic [sseg_pkg::SupW-1:0] sup_diff;
  logic [48:0]               env_sum;
  logic [40:0]               drop_sum;
  logic [49:0]               sup_sum;
  logic [sseg_pkg::SupW:0]   drop;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    mag_l  = left_sample_i[sseg_pkg::SampleW-1] ? 24'(-left_sample_i) : 24'(left_sample_i);
    mag_r  = right_sample_i[sseg_pkg::SampleW-1] ? 24'(-right_sample_i) : 24'(right_sample_i);
    rect_d = (stereo_en_q && (mag_r > mag_l)) ? mag_r : mag_l;
  end

  always_comb begin
    env_up   = rect_q >= env_q;
    env_diff = env_up ? (rect_q - env_q) : (env_q - rect_q);
    sup_up   = target_q >= supply_q;
    sup_diff = sup_up ? (target_q - supply_q) : (supply_q - target_q);
    env_sum  = 49'(prod_q[47:0]) + 49'd8388608;
    drop_sum = 41'(prod_q[39:0]) + 41'd16384;
    drop     = drop_sum[40:15];
    sup_sum  = 50'(prod_q[48:0]) + 50'd8388608;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sseg_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (sag_depth_q == '0) ? sseg_pkg::S_PASS : sseg_pkg::S_ENV;
        end
      end
      sseg_pkg::S_PASS:  if (slot_free) state_d = sseg_pkg::S_IDLE;
      sseg_pkg::S_ENV:   state_d = sseg_pkg::S_ENVU;
      sseg_pkg::S_ENVU:  state_d = sseg_pkg::S_DRP;
      sseg_pkg::S_DRP:   state_d = sseg_pkg::S_TGT;
      sseg_pkg::S_TGT:   state_d = sseg_pkg::S_SUP;
      sseg_pkg::S_SUP:   state_d = sseg_pkg::S_SUPU;
      sseg_pkg::S_SUPU:  state_d = sseg_pkg::S_LEFT;
      sseg_pkg::S_LEFT:  state_d = sseg_pkg::S_RIGHT;
      sseg_pkg::S_RIGHT: state_d = sseg_pkg::S_OUT;
      sseg_pkg::S_OUT:   if (slot_free) state_d = sseg_pkg::S_IDLE;
      default:           state_d = sseg_pkg::S_IDLE;
    endcase
  end

  // outputs: multiplier operands and handshakes
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    load_out = 1'b0;
    unique case (state_q) inside
      sseg_pkg::S_ENV: begin
        mul_a = {2'b00, env_diff};
        mul_b = {2'b00, (env_up ? attack_coef_q : release_coef_q)};
      end
      sseg_pkg::S_DRP: begin
        mul_a = {2'b00, env_q};
        mul_b = {10'd0, sag_depth_q};
      end
      sseg_pkg::S_SUP: begin
        mul_a = {1'b0, sup_diff};
        mul_b = {2'b00, (sup_up ? recover_coef_q : droop_coef_q)};
      end
      sseg_pkg::S_LEFT: begin
        mul_a = {{2{left_q[sseg_pkg::SampleW-1]}}, left_q};
        mul_b = {1'b0, supply_q};
      end
      sseg_pkg::S_RIGHT: begin
        mul_a = {{2{right_q[sseg_pkg::SampleW-1]}}, right_q};
        mul_b = {1'b0, supply_q};
      end
      sseg_pkg::S_PASS, sseg_pkg::S_OUT: load_out = slot_free;
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= sseg_pkg::S_IDLE;
      sag_depth_q    <= sseg_pkg::SagDepthRst;
      attack_coef_q  <= sseg_pkg::AttackCoefRst;
      release_coef_q <= sseg_pkg::ReleaseCoefRst;
      droop_coef_q   <= sseg_pkg::DroopCoefRst;
      recover_coef_q <= sseg_pkg::RecoverCoefRst;
      stereo_en_q    <= 1'b1;
      env_q          <= '0;
      supply_q       <= sseg_pkg::OneQ24;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sseg_pkg::RegSagDepth:    sag_depth_q    <= cfg_data_i[sseg_pkg::DepthW-1:0];
          sseg_pkg::RegAttackCoef:  attack_coef_q  <= cfg_data_i;
          sseg_pkg::RegReleaseCoef: release_coef_q <= cfg_data_i;
          sseg_pkg::RegDroopCoef:   droop_coef_q   <= cfg_data_i;
          sseg_pkg::RegRecoverCoef: recover_coef_q <= cfg_data_i;
          sseg_pkg::RegStereoEn:    stereo_en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_acc && (sag_depth_q == '0)) begin
        supply_q <= sseg_pkg::OneQ24;
      end
      if (state_q == sseg_pkg::S_ENVU) begin
        env_q <= env_up ? (env_q + env_sum[47:24]) : (env_q - env_sum[47:24]);
      end
      if (state_q == sseg_pkg::S_SUPU) begin
        supply_q <= sup_up ? (supply_q + sup_sum[48:24]) : (supply_q - sup_sum[48:24]);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // hold the right product while the result waits for a free slot
    if (state_q != sseg_pkg::S_OUT) begin
      prod_q <= prod_d;
    end
    if (in_acc) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
      rect_q  <= rect_d;
    end
    if (state_q == sseg_pkg::S_TGT) begin
      target_q <= (drop > sseg_pkg::MaxDrop) ? sseg_pkg::MinSupply
                                             : 25'(26'(sseg_pkg::OneQ24) - drop);
    end
    if (state_q == sseg_pkg::S_RIGHT) begin
      left_res_q <= sseg_pkg::sat_scale(prod_q);
    end
    if (load_out) begin
      if (state_q == sseg_pkg::S_PASS) begin
        left_out_q  <= left_q;
        right_out_q <= stereo_en_q ? right_q : '0;
      end else begin
        left_out_q  <= left_res_q;
        right_out_q <= stereo_en_q ? sseg_pkg::sat_scale(prod_q) : '0;
      end
    end
  end

  assign in_stall_o  = (state_q != sseg_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== hdl/sseg_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for supply_sag_envelope_gain_unit, with its bind statement.
// Depends on sseg_pkg for the sample width.
module sseg_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [sseg_pkg::SampleW-1:0] left_out_o,
  input logic signed [sseg_pkg::SampleW-1:0] right_out_o
);

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted beat");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a beat in flight");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_out_o) && $stable(right_out_o))
    else $error("result changed while stalled");

endmodule

bind supply_sag_envelope_gain_unit sseg_chk u_sseg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);
